// ----- src/khds_pkg.sv -----
// Shared types and constants for the k-mer histogram block.
`timescale 1ns / 1ps
package khds_pkg;

    localparam int unsigned MAX_WORD_LEN_DEF = 6;
    localparam int unsigned COUNT_WIDTH_DEF  = 32;
    localparam int unsigned TOTAL_W          = 32;
    localparam int unsigned SCORE_W          = 18;
    localparam int unsigned FRAC_BITS        = 16;
    localparam logic [SCORE_W-1:0] SCORE_MAX = 18'd131072;

    typedef enum logic [1:0] {
        OP_BASE   = 2'd0,
        OP_BREAK  = 2'd1,
        OP_FINISH = 2'd2,
        OP_CLEAR  = 2'd3
    } khds_op_t;

    typedef struct packed {
        logic accept;
        logic clr_step;
        logic rd_base;
        logic wr_base;
        logic walk_step;
        logic div_init;
        logic div_step;
        logic load_out;
    } khds_cmd_t;

    typedef struct packed {
        logic count_hit;
        logic clr_last;
        logic walk_last;
        logic pipe_busy;
        logic div_last;
        logic total_zero;
    } khds_sts_t;

endpackage

// ----- src/khds_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
module khds_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 4096
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;
endmodule

// ----- src/khds_ctrl.sv -----
// Controller state machine: sequences base updates, clearing, the finish walk and division.
`timescale 1ns / 1ps
module khds_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [1:0]          s_cmd,
    output logic                m_tvalid,
    input  logic                m_tready,
    output khds_pkg::khds_cmd_t cmd,
    input  khds_pkg::khds_sts_t sts
);
    import khds_pkg::*;

    typedef enum logic [7:0] {
        ST_CLEAR = 8'b0000_0001,
        ST_IDLE  = 8'b0000_0010,
        ST_BRD   = 8'b0000_0100,
        ST_BWR   = 8'b0000_1000,
        ST_WALK  = 8'b0001_0000,
        ST_DRAIN = 8'b0010_0000,
        ST_DIV   = 8'b0100_0000,
        ST_OUT   = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;
    logic   out_vld_reg, out_vld_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_CLEAR: begin
                cmd.clr_step = 1'b1;
                if (sts.clr_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.accept = 1'b1;
                    unique case (khds_op_t'(s_cmd))
                        OP_BASE:   if (sts.count_hit) state_next = ST_BRD;
                        OP_BREAK:  state_next = ST_IDLE;
                        OP_FINISH: state_next = sts.total_zero ? ST_OUT : ST_WALK;
                        OP_CLEAR:  state_next = ST_CLEAR;
                        default:   state_next = ST_IDLE;
                    endcase
                end
            end
            ST_BRD: begin
                cmd.rd_base = 1'b1;
                state_next  = ST_BWR;
            end
            ST_BWR: begin
                cmd.wr_base = 1'b1;
                state_next  = ST_IDLE;
            end
            ST_WALK: begin
                cmd.walk_step = 1'b1;
                if (sts.walk_last) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!sts.pipe_busy) begin
                    cmd.div_init = 1'b1;
                    state_next   = ST_DIV;
                end
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (sts.div_last) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!out_vld_reg || m_tready) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        out_vld_next = out_vld_reg;
        if (cmd.load_out) begin
            out_vld_next = 1'b1;
        end else if (m_tready) begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            out_vld_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            out_vld_reg <= out_vld_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_vld_reg;
endmodule

// ----- src/khds_datapath.sv -----
// Datapath: rolling word, bin store, deviation accumulator, serial divider, result register.
`timescale 1ns / 1ps
module khds_datapath #(
    parameter int unsigned MAX_WORD_LEN = khds_pkg::MAX_WORD_LEN_DEF,
    parameter int unsigned COUNT_WIDTH  = khds_pkg::COUNT_WIDTH_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  khds_pkg::khds_cmd_t                cmd,
    output khds_pkg::khds_sts_t                sts,
    input  logic [1:0]                         s_cmd,
    input  logic [1:0]                         s_base,
    input  logic [2:0]                         cfg_word_len,
    input  logic                               cfg_incl_empty,
    output logic [khds_pkg::SCORE_W-1:0]       score,
    output logic [khds_pkg::TOTAL_W-1:0]       total_bases,
    output logic                               no_data
);
    import khds_pkg::*;

    localparam int unsigned AW    = 2 * MAX_WORD_LEN;
    localparam int unsigned DEPTH = 1 << AW;
    localparam int unsigned KW    = $clog2(MAX_WORD_LEN + 1);
    localparam int unsigned SW    = $clog2(AW + 1);
    localparam int unsigned A_W   = COUNT_WIDTH + AW;
    localparam int unsigned DW    = (A_W > TOTAL_W) ? A_W : TOTAL_W;
    localparam int unsigned ACC_W = DW + AW;
    localparam int unsigned SC_W  = ACC_W + FRAC_BITS;
    localparam int unsigned DCW   = $clog2(SC_W + 1);

    logic [KW-1:0]          k_eff;
    logic [SW-1:0]          sh;
    logic [AW-1:0]          last_idx;

    logic [AW-1:0]          word_reg, word_next;
    logic [KW-1:0]          fill_reg, fill_next;
    logic [TOTAL_W-1:0]     total_reg;
    logic [AW-1:0]          idx_reg;
    logic [AW-1:0]          clr_cnt_reg;
    logic [AW-1:0]          walk_cnt_reg;

    logic                   ram_wr_en, ram_rd_en;
    logic [AW-1:0]          ram_wr_addr, ram_rd_addr;
    logic [COUNT_WIDTH-1:0] ram_wr_data, ram_rd_data;

    logic                   rd_vld_reg, d_vld_reg;
    logic [DW-1:0]          a_val, t_ext, d_val, d_reg;
    logic [ACC_W-1:0]       acc_reg;

    logic [SC_W-1:0]        dvd_reg;
    logic [TOTAL_W-1:0]     rem_reg;
    logic [TOTAL_W:0]       rem_sh;
    logic                   q_bit;
    logic [SCORE_W-1:0]     q_reg;
    logic                   sat_reg;
    logic [DCW-1:0]         div_cnt_reg;
    logic [4:0]             scale_sh;

    logic [SCORE_W-1:0]     score_reg;
    logic [TOTAL_W-1:0]     total_out_reg;
    logic                   nodata_reg;

    // Effective word length: zero acts as one, oversize clamps to the maximum.
    always_comb begin
        if (cfg_word_len == 3'd0) begin
            k_eff = KW'(1);
        end else if (32'(cfg_word_len) > MAX_WORD_LEN) begin
            k_eff = KW'(MAX_WORD_LEN);
        end else begin
            k_eff = KW'(cfg_word_len);
        end
    end

    assign sh       = SW'({k_eff, 1'b0});
    assign last_idx = AW'(((AW + 1)'(1) << sh) - (AW + 1)'(1));

    assign word_next = AW'({word_reg, s_base});
    assign fill_next = (32'(fill_reg) >= MAX_WORD_LEN) ? fill_reg : fill_reg + KW'(1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            word_reg  <= '0;
            fill_reg  <= '0;
            total_reg <= '0;
        end else if (cmd.accept) begin
            unique case (khds_op_t'(s_cmd))
                OP_BASE: begin
                    word_reg  <= word_next;
                    fill_reg  <= fill_next;
                    total_reg <= total_reg + TOTAL_W'(1);
                end
                OP_BREAK:  fill_reg <= '0;
                OP_CLEAR: begin
                    word_reg  <= '0;
                    fill_reg  <= '0;
                    total_reg <= '0;
                end
                OP_FINISH: ;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            idx_reg <= word_next & last_idx;
        end
    end

    // Clear sweep and walk counters.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg  <= '0;
            walk_cnt_reg <= '0;
            rd_vld_reg   <= 1'b0;
            d_vld_reg    <= 1'b0;
        end else begin
            if (cmd.accept) begin
                clr_cnt_reg  <= '0;
                walk_cnt_reg <= '0;
            end else begin
                if (cmd.clr_step)  clr_cnt_reg  <= clr_cnt_reg + AW'(1);
                if (cmd.walk_step) walk_cnt_reg <= walk_cnt_reg + AW'(1);
            end
            rd_vld_reg <= cmd.walk_step;
            d_vld_reg  <= rd_vld_reg;
        end
    end

    assign ram_rd_en   = cmd.rd_base | cmd.walk_step;
    assign ram_rd_addr = cmd.walk_step ? walk_cnt_reg : idx_reg;
    assign ram_wr_en   = cmd.clr_step | cmd.wr_base;
    assign ram_wr_addr = cmd.clr_step ? clr_cnt_reg : idx_reg;
    assign ram_wr_data = cmd.clr_step ? '0 : ram_rd_data + COUNT_WIDTH'(1);

    khds_ram #(
        .WIDTH (COUNT_WIDTH),
        .DEPTH (DEPTH)
    ) u_bins (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // Deviation of one bin: |N*count - total|, dropped for empty bins when excluded.
    assign a_val = DW'(ram_rd_data) << sh;
    assign t_ext = DW'(total_reg);
    always_comb begin
        if (!cfg_incl_empty && ram_rd_data == '0) begin
            d_val = '0;
        end else if (a_val >= t_ext) begin
            d_val = a_val - t_ext;
        end else begin
            d_val = t_ext - a_val;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_vld_reg) begin
            d_reg <= d_val;
        end
        if (cmd.accept) begin
            acc_reg <= '0;
        end else if (d_vld_reg) begin
            acc_reg <= acc_reg + ACC_W'(d_reg);
        end
    end

    // Restoring division, one quotient bit per cycle.
    assign scale_sh = 5'(FRAC_BITS) - 5'(sh);
    assign rem_sh   = {rem_reg, dvd_reg[SC_W-1]};
    assign q_bit    = (rem_sh >= {1'b0, total_reg});

    always_ff @(posedge aclk) begin
        if (cmd.div_init) begin
            dvd_reg     <= SC_W'(acc_reg) << scale_sh;
            rem_reg     <= '0;
            q_reg       <= '0;
            sat_reg     <= 1'b0;
            div_cnt_reg <= DCW'(SC_W);
        end else if (cmd.div_step) begin
            dvd_reg     <= dvd_reg << 1;
            rem_reg     <= q_bit ? TOTAL_W'(rem_sh - {1'b0, total_reg}) : TOTAL_W'(rem_sh);
            q_reg       <= {q_reg[SCORE_W-2:0], q_bit};
            sat_reg     <= sat_reg | q_reg[SCORE_W-1];
            div_cnt_reg <= div_cnt_reg - DCW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            total_out_reg <= total_reg;
            nodata_reg    <= (total_reg == '0);
            if (total_reg == '0) begin
                score_reg <= '0;
            end else if (sat_reg || q_reg > SCORE_MAX) begin
                score_reg <= SCORE_MAX;
            end else begin
                score_reg <= q_reg;
            end
        end
    end

    assign sts.count_hit  = (fill_next >= k_eff);
    assign sts.clr_last   = (clr_cnt_reg == AW'(DEPTH - 1));
    assign sts.walk_last  = (walk_cnt_reg == last_idx);
    assign sts.pipe_busy  = rd_vld_reg | d_vld_reg;
    assign sts.div_last   = (div_cnt_reg == DCW'(1));
    assign sts.total_zero = (total_reg == '0);

    assign score       = score_reg;
    assign total_bases = total_out_reg;
    assign no_data     = nodata_reg;
endmodule

// ----- src/kmer_histogram_with_deviation_score_core.sv -----
// Top level of the k-mer histogram with deviation score.
//
//  channel  | direction | contents
//  ---------+-----------+-----------------------------------------------
//  s_*      | in        | tuser = cmd, tdata = base (commands and bases)
//  m_*      | out       | tdata = score, total_bases; tuser = no_data
//  APB      | in/out    | word_length at 0x0, include_empty_bins at 0x4
//
// A base that counts reads its bin, then writes it back incremented. A clear sweeps
// all 4^MAX_WORD_LEN bins to zero, one bin per cycle. With a nonzero base total, a
// finish walks 4^k bins one per cycle through the bin memory read port, then runs a
// bit-serial division over the widened deviation sum, one quotient bit per cycle.
// After reset the bin memory is swept to zero, with s_tready low. A finished result
// waits in the output register; new transactions are taken meanwhile.
`timescale 1ns / 1ps
module kmer_histogram_with_deviation_score_core #(
    parameter int unsigned MAX_WORD_LEN = khds_pkg::MAX_WORD_LEN_DEF,
    parameter int unsigned COUNT_WIDTH  = khds_pkg::COUNT_WIDTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input transactions
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [1:0] base, [7:2] zero
    input  logic [1:0]  s_tuser,   // [1:0] cmd
    // result transactions
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // [17:0] score, [49:18] total_bases, [55:50] zero
    output logic        m_tuser,   // [0] no_data
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import khds_pkg::*;

    localparam logic [2:0] ADDR_WORD_LEN   = 3'd0;
    localparam logic [2:0] ADDR_INCL_EMPTY = 3'd4;

    logic [2:0]         word_len_reg;
    logic               incl_empty_reg;
    logic               cfg_wr;
    khds_cmd_t          cmd;
    khds_sts_t          sts;
    logic [SCORE_W-1:0] score;
    logic [TOTAL_W-1:0] total_bases;
    logic               no_data;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;

    // Register writes; out-of-map addresses are dropped.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            word_len_reg   <= 3'd3;
            incl_empty_reg <= 1'b1;
        end else if (cfg_wr) begin
            unique case (paddr)
                ADDR_WORD_LEN:   word_len_reg   <= pwdata[2:0];
                ADDR_INCL_EMPTY: incl_empty_reg <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr)
            ADDR_WORD_LEN:   prdata = {29'd0, word_len_reg};
            ADDR_INCL_EMPTY: prdata = {31'd0, incl_empty_reg};
            default:         prdata = '0;
        endcase
    end

    // Sequencing of each transaction.
    khds_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_cmd    (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    // Word tracking, bin store, scoring arithmetic.
    khds_datapath #(
        .MAX_WORD_LEN (MAX_WORD_LEN),
        .COUNT_WIDTH  (COUNT_WIDTH)
    ) u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .sts            (sts),
        .s_cmd          (s_tuser),
        .s_base         (s_tdata[1:0]),
        .cfg_word_len   (word_len_reg),
        .cfg_incl_empty (incl_empty_reg),
        .score          (score),
        .total_bases    (total_bases),
        .no_data        (no_data)
    );

    assign m_tdata = {6'd0, total_bases, score};
    assign m_tuser = no_data;
endmodule

// ----- bench/tb_kmer_histogram_with_deviation_score_core.sv -----
// Self-checking testbench for the k-mer histogram with deviation score block.
`timescale 1ns / 1ps
module tb_kmer_histogram_with_deviation_score_core;
    import khds_pkg::*;

    localparam int unsigned WORD_BITS  = 2 * MAX_WORD_LEN_DEF;
    localparam int unsigned BIN_COUNT  = 1 << WORD_BITS;
    localparam int unsigned CYCLE_CAP  = 30000000;
    // Longest quiet spell of the block: a clear sweeps every bin once.
    localparam int unsigned DRAIN_WAIT = BIN_COUNT + 200;
    localparam logic [2:0] ADDR_WORD_LEN = 3'd0;
    localparam logic [2:0] ADDR_EMPTY    = 3'd4;

    typedef struct {
        khds_op_t   op;
        logic [1:0] nt;
    } dna_item_t;

    typedef struct {
        logic [SCORE_W-1:0] score;
        logic [TOTAL_W-1:0] total;
        logic               empty;
    } score_result_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;   // [1:0] base, [7:2] zero
    logic [1:0]  s_tuser;   // [1:0] cmd
    logic        m_tvalid;
    logic        m_tready;
    logic [55:0] m_tdata;   // [17:0] score, [49:18] total_bases, [55:50] zero
    logic        m_tuser;   // [0] no_data
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    kmer_histogram_with_deviation_score_core dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // Shadow copy of the block's histogram state and registers.
    logic [31:0]          hist_bins [BIN_COUNT];
    logic [WORD_BITS-1:0] shadow_word;
    int unsigned          shadow_fill;
    logic [TOTAL_W-1:0]   shadow_total;
    logic [2:0]           shadow_k_reg;
    logic                 shadow_all_bins;

    dna_item_t     pending_bases [$];
    score_result_t awaited_scores [$];

    int unsigned errors;
    int unsigned items_taken;
    int unsigned scores_seen;
    int unsigned finishes_sent;
    int unsigned phases_run;
    int unsigned cycle_count;
    bit          steady_flow;
    bit          pressure_req;
    bit          pressure_done;

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // Clamp the word length register to the range that the histogram honours.
    function automatic int unsigned live_k();
        if (shadow_k_reg == 3'd0) return 1;
        if (shadow_k_reg > MAX_WORD_LEN_DEF) return MAX_WORD_LEN_DEF;
        return shadow_k_reg;
    endfunction

    // floor(65536 * sum|N*count - total| / (N*total)), saturated.
    function automatic logic [SCORE_W-1:0] deviation_score();
        int unsigned  k;
        int unsigned  sh;
        logic [63:0]  scaled;
        logic [63:0]  tot;
        logic [63:0]  dev;
        logic [127:0] acc;
        logic [127:0] quo;
        k   = live_k();
        sh  = 2 * k;
        tot = {32'd0, shadow_total};
        acc = '0;
        for (int unsigned i = 0; i < (1 << sh); i++) begin
            if (!shadow_all_bins && hist_bins[i] == 32'd0) continue;
            scaled = {32'd0, hist_bins[i]} << sh;
            dev    = (scaled >= tot) ? scaled - tot : tot - scaled;
            acc    = acc + {64'd0, dev};
        end
        acc = acc << (FRAC_BITS - sh);
        quo = acc / {64'd0, tot};
        if (quo > 128'd131072) return SCORE_MAX;
        return quo[SCORE_W-1:0];
    endfunction

    // Advance the shadow state by one accepted transaction.
    task automatic apply_item(input dna_item_t it);
        score_result_t res;
        int unsigned   k;
        logic [WORD_BITS-1:0] idx;
        case (it.op)
            OP_BASE: begin
                k = live_k();
                shadow_total = shadow_total + 1;
                shadow_word  = {shadow_word[WORD_BITS-3:0], it.nt};
                if (shadow_fill < MAX_WORD_LEN_DEF) shadow_fill++;
                if (shadow_fill >= k) begin
                    idx = shadow_word & WORD_BITS'((1 << (2 * k)) - 1);
                    hist_bins[idx] = hist_bins[idx] + 1;
                end
            end
            OP_BREAK: shadow_fill = 0;
            OP_CLEAR: begin
                foreach (hist_bins[i]) hist_bins[i] = '0;
                shadow_word  = '0;
                shadow_fill  = 0;
                shadow_total = '0;
            end
            default: begin
                if (shadow_total == '0) begin
                    res.score = '0;
                    res.total = '0;
                    res.empty = 1'b1;
                end else begin
                    res.score = deviation_score();
                    res.total = shadow_total;
                    res.empty = 1'b0;
                end
                awaited_scores.push_back(res);
            end
        endcase
    endtask

    // Mostly back-to-back, sometimes a short gap, now and then a long one.
    function automatic int unsigned pick_gap();
        int unsigned r;
        if (steady_flow) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Input driver: offer queued items, update the shadow on each handshake.
    dna_item_t   offered;
    int unsigned src_gap;
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= OP_BASE;
            src_gap  = 0;
        end else begin
            if (s_tvalid && s_tready) begin
                apply_item(offered);
                items_taken++;
            end
            if (!s_tvalid || s_tready) begin
                if (src_gap > 0) begin
                    src_gap--;
                    s_tvalid <= 1'b0;
                end else if (pending_bases.size() > 0) begin
                    offered = pending_bases.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser  <= offered.op;
                    s_tdata  <= {6'd0, offered.nt};
                    src_gap  = pick_gap();
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: check each result transaction, stall the output at random.
    int unsigned   sink_hold;
    score_result_t want;
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready  <= 1'b0;
            sink_hold = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                scores_seen++;
                if (awaited_scores.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result expected none actual score=%0d total=%0d nd=%0b",
                             $time, m_tdata[17:0], m_tdata[49:18], m_tuser);
                end else begin
                    want = awaited_scores.pop_front();
                    if (m_tdata[17:0] !== want.score) begin
                        errors++;
                        $display("%0t: score mismatch expected %0d actual %0d",
                                 $time, want.score, m_tdata[17:0]);
                    end
                    if (m_tdata[49:18] !== want.total) begin
                        errors++;
                        $display("%0t: total_bases mismatch expected %0d actual %0d",
                                 $time, want.total, m_tdata[49:18]);
                    end
                    if (m_tuser !== want.empty) begin
                        errors++;
                        $display("%0t: no_data mismatch expected %0b actual %0b",
                                 $time, want.empty, m_tuser);
                    end
                end
            end
            // Hold off for a long stretch once, so the output register fills.
            if (pressure_req && !pressure_done) begin
                pressure_done = 1'b1;
                sink_hold = 3000;
            end
            if (sink_hold > 0) begin
                sink_hold--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                sink_hold = pick_gap();
            end
        end
    end

    // Watchdog.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_CAP) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic reg_write(input logic [2:0] addr, input logic [31:0] val);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == ADDR_WORD_LEN) shadow_k_reg = val[2:0];
        else shadow_all_bins = val[0];
        @(negedge aclk);
    endtask

    task automatic push_item(input khds_op_t op, input logic [1:0] nt);
        dna_item_t it;
        it.op = op;
        it.nt = nt;
        if (op == OP_FINISH) finishes_sent++;
        pending_bases.push_back(it);
    endtask

    // Hold the sender until every expected result has come and the block is quiet.
    task automatic drain();
        while (pending_bases.size() > 0 || s_tvalid || awaited_scores.size() > 0)
            @(negedge aclk);
        repeat (DRAIN_WAIT) @(negedge aclk);
    endtask

    // Runs of bases with random content, separated by breaks and finishes;
    // a few clears as noise.
    task automatic fill_random(input int unsigned n_items);
        int unsigned made;
        int unsigned run;
        int unsigned r;
        made = 0;
        while (made < n_items) begin
            run = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 80) : $urandom_range(0, 20);
            repeat (run) push_item(OP_BASE, 2'($urandom_range(0, 3)));
            made += run;
            r = $urandom_range(0, 99);
            if (r < 45) push_item(OP_FINISH, 2'($urandom_range(0, 3)));
            else if (r < 85) push_item(OP_BREAK, 2'($urandom_range(0, 3)));
            else if (r < 88) push_item(OP_CLEAR, 2'($urandom_range(0, 3)));
            made++;
        end
    endtask

    int unsigned phase_k     [9] = '{1, 2, 4, 6, 5, 0, 7, 3, 6};
    int unsigned phase_empty [9] = '{1, 0, 1, 0, 1, 0, 1, 0, 1};

    initial begin
        aresetn  = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        errors = 0; items_taken = 0; scores_seen = 0; finishes_sent = 0;
        phases_run = 0; cycle_count = 0;
        steady_flow = 1'b0; pressure_req = 1'b0; pressure_done = 1'b0;
        foreach (hist_bins[i]) hist_bins[i] = '0;
        shadow_word = '0; shadow_fill = 0; shadow_total = '0;
        shadow_k_reg = 3'd3; shadow_all_bins = 1'b1;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed: empty finish, every base code, breaks, clear, reset-value registers.
        push_item(OP_FINISH, 2'd3);
        push_item(OP_BASE, 2'd0);
        push_item(OP_BASE, 2'd1);
        push_item(OP_BASE, 2'd2);
        push_item(OP_BASE, 2'd3);
        push_item(OP_BASE, 2'd3);
        push_item(OP_FINISH, 2'd0);
        push_item(OP_BREAK, 2'd2);
        push_item(OP_BASE, 2'd1);
        push_item(OP_BASE, 2'd2);
        push_item(OP_FINISH, 2'd1);
        push_item(OP_BASE, 2'd0);
        push_item(OP_FINISH, 2'd2);
        push_item(OP_CLEAR, 2'd1);
        push_item(OP_FINISH, 2'd0);
        push_item(OP_BASE, 2'd3);
        push_item(OP_BREAK, 2'd0);
        push_item(OP_FINISH, 2'd3);
        drain();

        // Random phases over a sweep of register settings, state carried across.
        for (int p = 0; p < 9; p++) begin
            reg_write(ADDR_WORD_LEN, phase_k[p]);
            reg_write(ADDR_EMPTY, phase_empty[p]);
            steady_flow = (p == 2);
            if (p == 4) begin
                // Flood finishes while the receiver holds off.
                pressure_req = 1'b1;
                repeat (6) begin
                    repeat (5) push_item(OP_BASE, 2'($urandom_range(0, 3)));
                    push_item(OP_FINISH, 2'd0);
                end
            end
            fill_random(190);
            drain();
            phases_run++;
        end

        $display("Covered %0d transactions in %0d register settings, word lengths 0 to 7,",
                 items_taken, phases_run + 1);
        $display("with %0d finishes scored and %0d results checked.", finishes_sent, scores_seen);
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
